@@ rtl/core/encoder_heading_odometry_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the odometry checker
// ----------------------------------------------------------------------------
`ifndef ENCODER_HEADING_ODOMETRY_ASSERT_SVH
`define ENCODER_HEADING_ODOMETRY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define EHO_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("odometry check failed in same cycle");

// Consequent must hold in the cycle after the antecedent
`define EHO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("odometry check failed in next cycle");

`endif

@@ rtl/core/eho_pkg.sv @@
// ----------------------------------------------------------------------------
// eho_pkg
// Types, constants and the arctangent table of the odometry block.
// ----------------------------------------------------------------------------
package eho_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FEET_PER_TICK = 2'd0,
    CFG_START_X       = 2'd1,
    CFG_START_Y       = 2'd2
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_ACC,
    ST_APPLY,
    ST_DONE
  } state_t;

  // Partial product steps of the shared multiplier
  typedef enum logic [2:0] {
    MS_DIST_LO = 3'd0,
    MS_DIST_HI = 3'd1,
    MS_SIN_LO  = 3'd2,
    MS_SIN_HI  = 3'd3,
    MS_COS_LO  = 3'd4,
    MS_COS_HI  = 3'd5
  } mul_step_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       cordic_en;
    logic [4:0] iter;
    logic       mul_en;
    logic       acc_en;
    logic       apply_en;
    mul_step_t  step;
    logic       finish;
  } cmd_t;

  localparam int unsigned ATAN_LEN = 24;

  localparam logic [31:0]        FPT_RESET    = 32'd1647099;
  localparam logic signed [31:0] X_OFF_RESET  = 32'sd29491;
  localparam logic signed [31:0] Y_OFF_RESET  = -32'sd24904;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  localparam logic signed [16:0] DEG_FULL    = 17'sd36000;
  localparam logic signed [16:0] DEG_HALF    = 17'sd18000;
  localparam logic signed [16:0] DEG_QUARTER = 17'sd9000;

  localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

  // Arctangent of 2^-i in units of 1/6553600 degree
  function automatic logic [28:0] atan_units(input logic [4:0] i);
    logic [28:0] v;
    unique case (i)
      5'd0:  v = 29'd294912000;
      5'd1:  v = 29'd174096719;
      5'd2:  v = 29'd91987925;
      5'd3:  v = 29'd46694507;
      5'd4:  v = 29'd23437865;
      5'd5:  v = 29'd11730358;
      5'd6:  v = 29'd5866610;
      5'd7:  v = 29'd2933484;
      5'd8:  v = 29'd1466764;
      5'd9:  v = 29'd733385;
      5'd10: v = 29'd366693;
      5'd11: v = 29'd183346;
      5'd12: v = 29'd91673;
      5'd13: v = 29'd45837;
      5'd14: v = 29'd22918;
      5'd15: v = 29'd11459;
      5'd16: v = 29'd5730;
      5'd17: v = 29'd2865;
      5'd18: v = 29'd1432;
      5'd19: v = 29'd716;
      5'd20: v = 29'd358;
      5'd21: v = 29'd179;
      5'd22: v = 29'd90;
      5'd23: v = 29'd45;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

  // Add a signed magnitude step to an accumulator and saturate to 32 bits
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic [49:0] mag,
                                                 input logic neg);
    logic signed [51:0] stp;
    logic signed [51:0] sum;
    stp = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum = $signed({{20{acc[31]}}, acc}) + stp;
    if (sum > SAT_MAX) begin
      return SAT_MAX[31:0];
    end else if (sum < SAT_MIN) begin
      return SAT_MIN[31:0];
    end
    return sum[31:0];
  endfunction

endpackage

@@ rtl/core/encoder_heading_odometry.sv @@
// ----------------------------------------------------------------------------
// encoder_heading_odometry
// Dead-reckoning odometry from an absolute encoder count and a gyro yaw.
// ----------------------------------------------------------------------------
// Each update item moves X by distance*sin(yaw) and Y by distance*cos(yaw),
// both saturating Q15.16 feet, and stores the count; a reset item zeroes X, Y
// and the stored count. Every item gives one result with X, Y and the heading
// wrapped to 1..36000 hundredths of a degree. An update item runs
// TRIG_ITERATIONS CORDIC rotations (values above 24 act as 24), then three
// products (distance, sine step, cosine step) of two 24x32 partial products
// each through one shared multiplier, every partial product taking a multiply
// and an accumulate step and every product a rounding step, and then loads
// the result. A reset item skips the rotations and products and goes straight
// to the load. A stalled result holds the block before the load; once the
// result is loaded the next item is taken while that result still waits.
// Hardware reset loads X and Y from the offset reset values; offset writes
// have no effect on a running block.
module encoder_heading_odometry #(
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic signed [31:0] encoder_count,
  input  logic signed [15:0] yaw_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] x_position,
  output logic signed [31:0] y_position,
  output logic [15:0]        heading_wrapped
);

  eho_pkg::cmd_t cmd;

  // Sequencer
  eho_ctrl #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Arithmetic
  eho_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .command         (command),
    .encoder_count   (encoder_count),
    .yaw_angle       (yaw_angle),
    .x_position      (x_position),
    .y_position      (y_position),
    .heading_wrapped (heading_wrapped)
  );

endmodule

@@ rtl/core/eho_datapath.sv @@
// ----------------------------------------------------------------------------
// eho_datapath
// Accumulators, CORDIC rotator, shared 24x32 multiplier and result registers.
// ----------------------------------------------------------------------------
module eho_datapath (
  input  logic                clk,
  input  logic                rst,
  input  eho_pkg::cmd_t       cmd,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata,
  input  logic                command,
  input  logic signed [31:0]  encoder_count,
  input  logic signed [15:0]  yaw_angle,
  output logic signed [31:0]  x_position,
  output logic signed [31:0]  y_position,
  output logic [15:0]         heading_wrapped
);

  logic [31:0]        feet_per_tick;
  logic signed [31:0] x_accum;
  logic signed [31:0] y_accum;
  logic signed [31:0] last_count;
  logic [32:0]        ticks;
  logic               dist_neg;
  logic               flip;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [31:0] cz;
  logic [47:0]        travel;
  logic [55:0]        mres;
  logic [79:0]        psum;
  logic [15:0]        heading;

  logic signed [32:0] delta;
  logic signed [16:0] yaw_s;
  logic signed [16:0] ang0;
  logic signed [16:0] ang1;
  logic signed [16:0] ang2;
  logic               flip_in;
  logic [17:0]        head_s;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [31:0] atan_s;
  logic [23:0]        op_a;
  logic [31:0]        op_b;
  logic [31:0]        sin_mag;
  logic [31:0]        cos_mag;
  logic [33:0]        cy_abs;
  logic [33:0]        cx_abs;
  logic [49:0]        qround;

  // Configuration: only the scale is live, offsets act through reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      feet_per_tick <= eho_pkg::FPT_RESET;
    end else if (cfg_wr_en && (cfg_addr == eho_pkg::CFG_FEET_PER_TICK)) begin
      feet_per_tick <= cfg_wdata;
    end
  end

  // Tick difference, angle reduction and heading wrap
  always_comb begin
    delta   = {last_count[31], last_count} - {encoder_count[31], encoder_count};
    yaw_s   = {yaw_angle[15], yaw_angle};
    ang0    = yaw_s[16] ? yaw_s + eho_pkg::DEG_FULL : yaw_s;
    ang1    = (ang0 >= eho_pkg::DEG_HALF) ? ang0 - eho_pkg::DEG_FULL : ang0;
    flip_in = 1'b0;
    ang2    = ang1;
    if (ang1 > eho_pkg::DEG_QUARTER) begin
      ang2    = ang1 - eho_pkg::DEG_HALF;
      flip_in = 1'b1;
    end else if (ang1 < -eho_pkg::DEG_QUARTER) begin
      ang2    = ang1 + eho_pkg::DEG_HALF;
      flip_in = 1'b1;
    end
    // Always positive: the lowest yaw plus a full turn is still above zero
    head_s = {yaw_s[16], yaw_s} + {1'b0, eho_pkg::DEG_FULL};
    if (head_s > {1'b0, eho_pkg::DEG_FULL}) begin
      head_s = head_s - {1'b0, eho_pkg::DEG_FULL};
    end
  end

  // One CORDIC micro-rotation
  always_comb begin
    dx     = cy >>> cmd.iter;
    dy     = cx >>> cmd.iter;
    atan_s = $signed({3'b000, eho_pkg::atan_units(cmd.iter)});
  end

  // Operand select for the shared multiplier
  always_comb begin
    cy_abs  = cy[33] ? 34'(-cy) : 34'(cy);
    cx_abs  = cx[33] ? 34'(-cx) : 34'(cx);
    sin_mag = cy_abs[31:0];
    cos_mag = cx_abs[31:0];
    unique case (cmd.step)
      eho_pkg::MS_DIST_LO: begin op_a = ticks[23:0];          op_b = feet_per_tick; end
      eho_pkg::MS_DIST_HI: begin op_a = {15'd0, ticks[32:24]}; op_b = feet_per_tick; end
      eho_pkg::MS_SIN_LO:  begin op_a = travel[23:0];         op_b = sin_mag;       end
      eho_pkg::MS_SIN_HI:  begin op_a = travel[47:24];        op_b = sin_mag;       end
      eho_pkg::MS_COS_LO:  begin op_a = travel[23:0];         op_b = cos_mag;       end
      eho_pkg::MS_COS_HI:  begin op_a = travel[47:24];        op_b = cos_mag;       end
      default:             begin op_a = '0;                   op_b = '0;            end
    endcase
    qround = 50'((psum + (80'd1 << 29)) >> 30);
  end

  // Accumulators and the stored count
  always_ff @(posedge clk) begin
    if (rst) begin
      x_accum    <= eho_pkg::X_OFF_RESET;
      y_accum    <= eho_pkg::Y_OFF_RESET;
      last_count <= '0;
    end else if (cmd.load) begin
      if (command) begin
        x_accum    <= '0;
        y_accum    <= '0;
        last_count <= '0;
      end else begin
        last_count <= encoder_count;
      end
    end else if (cmd.apply_en && (cmd.step == eho_pkg::MS_SIN_HI)) begin
      x_accum <= eho_pkg::sat_add(x_accum, qround, dist_neg ^ flip ^ cy[33]);
    end else if (cmd.apply_en && (cmd.step == eho_pkg::MS_COS_HI)) begin
      y_accum <= eho_pkg::sat_add(y_accum, qround, dist_neg ^ flip ^ cx[33]);
    end
  end

  // Working registers: item setup, rotation, products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dist_neg <= delta[32];
      ticks    <= delta[32] ? 33'(-delta) : 33'(delta);
      flip     <= flip_in;
      cx       <= eho_pkg::CORDIC_START;
      cy       <= '0;
      cz       <= $signed({{15{ang2[16]}}, ang2}) <<< 16;
      heading  <= head_s[15:0];
    end else if (cmd.cordic_en) begin
      if (!cz[31]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - atan_s;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + atan_s;
      end
    end
    if (cmd.mul_en) begin
      mres <= op_a * op_b;
    end
    if (cmd.acc_en) begin
      if (cmd.step[0]) begin
        psum <= psum + ({24'd0, mres} << 24);
      end else begin
        psum <= {24'd0, mres};
      end
    end
    if (cmd.apply_en && (cmd.step == eho_pkg::MS_DIST_HI)) begin
      travel <= 48'((psum + 80'd32768) >> 16);
    end
  end

  // Result registers, held while the result waits
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      x_position      <= x_accum;
      y_position      <= y_accum;
      heading_wrapped <= heading;
    end
  end

endmodule

@@ rtl/core/eho_ctrl.sv @@
// ----------------------------------------------------------------------------
// eho_ctrl
// Sequencer: CORDIC iterations, multiplier steps and the result handshake.
// ----------------------------------------------------------------------------
module eho_ctrl #(
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          command,
  output logic          out_valid,
  input  logic          out_ready,
  output eho_pkg::cmd_t cmd
);

  localparam int unsigned ITERS =
    (TRIG_ITERATIONS > eho_pkg::ATAN_LEN) ? eho_pkg::ATAN_LEN : TRIG_ITERATIONS;
  localparam logic [4:0] LAST_ITER = 5'(ITERS - 1);

  eho_pkg::state_t   state;
  eho_pkg::state_t   state_next;
  logic [4:0]        iter;
  eho_pkg::mul_step_t step;
  logic              out_free;

  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      eho_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = command ? eho_pkg::ST_DONE : eho_pkg::ST_CORDIC;
        end
      end
      eho_pkg::ST_CORDIC: begin
        if (iter == LAST_ITER) begin
          state_next = eho_pkg::ST_MUL;
        end
      end
      eho_pkg::ST_MUL: state_next = eho_pkg::ST_ACC;
      eho_pkg::ST_ACC: begin
        state_next = step[0] ? eho_pkg::ST_APPLY : eho_pkg::ST_MUL;
      end
      eho_pkg::ST_APPLY: begin
        state_next = (step == eho_pkg::MS_COS_HI) ? eho_pkg::ST_DONE : eho_pkg::ST_MUL;
      end
      eho_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = eho_pkg::ST_IDLE;
        end
      end
      default: state_next = eho_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = (state == eho_pkg::ST_IDLE);
    cmd.load      = (state == eho_pkg::ST_IDLE) && in_valid;
    cmd.cordic_en = (state == eho_pkg::ST_CORDIC);
    cmd.iter      = iter;
    cmd.mul_en    = (state == eho_pkg::ST_MUL);
    cmd.acc_en    = (state == eho_pkg::ST_ACC);
    cmd.apply_en  = (state == eho_pkg::ST_APPLY);
    cmd.step      = step;
    cmd.finish    = (state == eho_pkg::ST_DONE) && out_free;
  end

  // State, counters and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= eho_pkg::ST_IDLE;
      iter      <= '0;
      step      <= eho_pkg::MS_DIST_LO;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == eho_pkg::ST_IDLE) begin
        iter <= '0;
        step <= eho_pkg::MS_DIST_LO;
      end else if (state == eho_pkg::ST_CORDIC) begin
        iter <= iter + 5'd1;
      end else if ((state == eho_pkg::ST_ACC) && !step[0]) begin
        step <= eho_pkg::mul_step_t'(step + 3'd1);
      end else if ((state == eho_pkg::ST_APPLY) && (step != eho_pkg::MS_COS_HI)) begin
        step <= eho_pkg::mul_step_t'(step + 3'd1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/eho_checker.sv @@
// ----------------------------------------------------------------------------
// eho_checker
// Port-level checks on the odometry block, bound to its top level.
// ----------------------------------------------------------------------------
`include "encoder_heading_odometry_assert.svh"

module eho_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] x_position,
  input logic [15:0] heading_wrapped
);

  // Heading always lands in the wrapped range
  `EHO_ASSERT_SAME(a_heading_range, out_valid, heading_wrapped <= 16'd36000)

  // Block turns busy once it has taken an item
  `EHO_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A new result only appears at the end of an item's work
  `EHO_ASSERT_SAME(a_result_from_busy, $rose(out_valid), !$past(in_ready))

  // A stalled result holds
  `EHO_ASSERT_NEXT(a_result_hold, out_valid && !out_ready,
                   out_valid && $stable(x_position) && $stable(heading_wrapped))

endmodule

bind encoder_heading_odometry eho_checker u_eho_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .x_position      (x_position),
  .heading_wrapped (heading_wrapped)
);
